### src/nsag_pkg.sv
// ----------------------------------------------------------------------------
// nsag_pkg: shared types and constants of the nearest-neighbor scaler
// Field widths, register indexes, transfer structs and divider geometry.
// ----------------------------------------------------------------------------
package nsag_pkg;

  // Field widths
  localparam int COORD_W   = 12;             // pixel coordinate
  localparam int DIM_W     = 13;             // image dimension register
  localparam int PROD_W    = COORD_W + DIM_W; // coordinate times dimension
  localparam int IDX_W     = PROD_W;         // destination pixel index
  localparam int OFF_W     = 26;             // byte offset
  localparam int QUO_W     = DIM_W;          // source coordinate before masking
  localparam int CFG_IDX_W = 3;

  // Divider geometry: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam int MAX_DIM_DEFAULT = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

  // Input item: one destination pixel coordinate
  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [OFF_W-1:0]   in_byte_offset;
    logic [OFF_W-1:0]   out_byte_offset;
    logic               coord_error;
  } out_item_t;

  // Sideband that rides along the divider
  typedef struct packed {
    logic             err;
    logic [IDX_W-1:0] dst_idx;
  } side_t;

  // Divider request and response
  typedef struct packed {
    logic [PROD_W-1:0] dvd_col;
    logic [PROD_W-1:0] dvd_row;
    side_t             side;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo_col;
    logic [QUO_W-1:0] quo_row;
    side_t            side;
  } div_rsp_t;

endpackage

### src/nearest_scaler_address_gen_top.sv
// ----------------------------------------------------------------------------
// nearest_scaler_address_gen_top: nearest-neighbor RGB24 scaler addressing
// Maps a destination pixel to its nearest source pixel and returns both
// pixel byte offsets (index times three).
//
//   port group | dir | handshake        | payload
//   -----------+-----+------------------+----------------------------------
//   in_        | in  | in_valid/in_stall| in_item_t  (out_col, out_row)
//   out_       | out | out_valid/       | out_item_t (in_col, in_row,
//              |     |   out_stall      |   in/out_byte_offset, coord_error)
//   cfg_       | in  | cfg_we           | cfg_index, cfg_data (13 bits)
//
// One item per clock while out_stall does not hold the pipeline full; the stages
// are: input stage, seven divider stages (two quotient bits each, one in the last),
// source multiply, output register. The divider pipeline depth sets the latency.
// Synchronous active-low reset empties every stage; config registers read as 1.
// Each stage advances when it is empty or the one after it moves, so an
// output stall fills bubbles first and blocks input only when all are full.
// ----------------------------------------------------------------------------
module nearest_scaler_address_gen_top
  import nsag_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Zero reads as one, values above MAX_DIM saturate
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = DIM_W'(1);
    end else if (int'(raw) > MAX_DIM) begin
      v = DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // Configuration registers hold the effective dimension
  logic [DIM_W-1:0] src_w_r;
  logic [DIM_W-1:0] src_h_r;
  logic [DIM_W-1:0] dst_w_r;
  logic [DIM_W-1:0] dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(1);
      src_h_r <= DIM_W'(1);
      dst_w_r <= DIM_W'(1);
      dst_h_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_w_r <= eff_dim(cfg_data);
        CFG_SRC_HEIGHT: src_h_r <= eff_dim(cfg_data);
        CFG_DST_WIDTH:  dst_w_r <= eff_dim(cfg_data);
        CFG_DST_HEIGHT: dst_h_r <= eff_dim(cfg_data);
        default: ;
      endcase
    end
  end

  // Handshake chain, output side back to input side
  logic     s1_vld_r;
  div_req_t s1_req_r;
  div_req_t s1_req_nxt;
  logic     s1_rdy;
  logic     div_req_ready;
  logic     div_rsp_valid;
  div_rsp_t div_rsp;
  logic     m_vld_r;
  logic     m_rdy;
  div_rsp_t m_rsp_r;
  logic [OFF_W-1:0] m_prod_r;
  logic [OFF_W-1:0] m_prod_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      out_rdy;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign m_rdy    = !m_vld_r || out_rdy;
  assign s1_rdy   = !s1_vld_r || div_req_ready;
  assign in_stall = !s1_rdy;

  // Stage 1: range check, dividend products, destination index
  always_comb begin
    logic err;
    err = ({1'b0, in_data.out_col} >= dst_w_r) || ({1'b0, in_data.out_row} >= dst_h_r);
    s1_req_nxt.side.err     = err;
    s1_req_nxt.side.dst_idx = IDX_W'(in_data.out_row) * IDX_W'(dst_w_r)
                              + IDX_W'(in_data.out_col);
    s1_req_nxt.dvd_col = err ? '0 : PROD_W'(in_data.out_col) * PROD_W'(src_w_r);
    s1_req_nxt.dvd_row = err ? '0 : PROD_W'(in_data.out_row) * PROD_W'(src_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_req_r <= s1_req_nxt;
    end
  end

  // Divide by destination width and height
  nsag_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .dvs_col   (dst_w_r),
    .dvs_row   (dst_h_r),
    .req_valid (s1_vld_r),
    .req_ready (div_req_ready),
    .req       (s1_req_r),
    .rsp_valid (div_rsp_valid),
    .rsp_ready (m_rdy),
    .rsp       (div_rsp)
  );

  // Source row times source width
  assign m_prod_nxt = OFF_W'(div_rsp.quo_row) * OFF_W'(src_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_rdy) begin
      m_vld_r <= div_rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && div_rsp_valid) begin
      m_rsp_r  <= div_rsp;
      m_prod_r <= m_prod_nxt;
    end
  end

  // Output stage: add column, scale by three bytes per pixel; error items read as zero with coord_error set
  always_comb begin
    logic [OFF_W-1:0] src_idx;
    logic [OFF_W-1:0] dst_idx;
    src_idx = m_prod_r + OFF_W'(m_rsp_r.quo_col);
    dst_idx = OFF_W'(m_rsp_r.side.dst_idx);
    if (m_rsp_r.side.err) begin
      out_data_nxt             = '0;
      out_data_nxt.coord_error = 1'b1;
    end else begin
      out_data_nxt.in_col          = m_rsp_r.quo_col[COORD_W-1:0];
      out_data_nxt.in_row          = m_rsp_r.quo_row[COORD_W-1:0];
      out_data_nxt.in_byte_offset  = src_idx + (src_idx << 1);
      out_data_nxt.out_byte_offset = dst_idx + (dst_idx << 1);
      out_data_nxt.coord_error     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && m_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/nsag_div_pipe.sv
// ----------------------------------------------------------------------------
// nsag_div_pipe: pipelined restoring divider pair
// Divides the column and row products by the destination width and height,
// up to DIV_STEPS quotient bits per stage, with a bubble-collapsing handshake.
// ----------------------------------------------------------------------------
module nsag_div_pipe
  import nsag_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] dvs_col,
  input  logic [DIM_W-1:0] dvs_row,
  input  logic             req_valid,
  output logic             req_ready,
  input  div_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output div_rsp_t         rsp
);

  // Stage registers
  logic [DIV_STAGES-1:0] vld_r;
  logic [PROD_W-1:0]     rem_col_r [DIV_STAGES];
  logic [PROD_W-1:0]     rem_row_r [DIV_STAGES];
  logic [QUO_W-1:0]      quo_col_r [DIV_STAGES];
  logic [QUO_W-1:0]      quo_row_r [DIV_STAGES];
  side_t                 side_r    [DIV_STAGES];

  // Stage inputs and next values
  logic [DIV_STAGES-1:0] src_vld;
  logic [PROD_W-1:0]     src_rem_col [DIV_STAGES];
  logic [PROD_W-1:0]     src_rem_row [DIV_STAGES];
  logic [QUO_W-1:0]      src_quo_col [DIV_STAGES];
  logic [QUO_W-1:0]      src_quo_row [DIV_STAGES];
  side_t                 src_side    [DIV_STAGES];
  logic [PROD_W-1:0]     rem_col_nxt [DIV_STAGES];
  logic [PROD_W-1:0]     rem_row_nxt [DIV_STAGES];
  logic [QUO_W-1:0]      quo_col_nxt [DIV_STAGES];
  logic [QUO_W-1:0]      quo_row_nxt [DIV_STAGES];

  // A stage can load when it is empty or its content moves on
  logic [DIV_STAGES:0] rdy;

  assign rdy[DIV_STAGES] = rsp_ready;
  assign req_ready       = rdy[0];

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stg

      assign rdy[s] = !vld_r[s] || rdy[s+1];

      // Stage source: the request or the previous stage
      if (s == 0) begin : g_first
        assign src_vld[s]     = req_valid;
        assign src_rem_col[s] = req.dvd_col;
        assign src_rem_row[s] = req.dvd_row;
        assign src_quo_col[s] = '0;
        assign src_quo_row[s] = '0;
        assign src_side[s]    = req.side;
      end else begin : g_next
        assign src_vld[s]     = vld_r[s-1];
        assign src_rem_col[s] = rem_col_r[s-1];
        assign src_rem_row[s] = rem_row_r[s-1];
        assign src_quo_col[s] = quo_col_r[s-1];
        assign src_quo_row[s] = quo_row_r[s-1];
        assign src_side[s]    = side_r[s-1];
      end

      // Restoring steps, MSB first; quotient bits shift in from the right
      always_comb begin
        logic [PROD_W-1:0] rc;
        logic [PROD_W-1:0] rr;
        logic [QUO_W-1:0]  qc;
        logic [QUO_W-1:0]  qr;
        logic [PROD_W-1:0] dc;
        logic [PROD_W-1:0] dr;
        int                b;
        rc = src_rem_col[s];
        rr = src_rem_row[s];
        qc = src_quo_col[s];
        qr = src_quo_row[s];
        dc = '0;
        dr = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
          b = QUO_W - 1 - s * DIV_STEPS - j;
          if (b >= 0) begin
            dc = {{(PROD_W-DIM_W){1'b0}}, dvs_col} << b;
            dr = {{(PROD_W-DIM_W){1'b0}}, dvs_row} << b;
            if (rc >= dc) begin
              rc = rc - dc;
              qc = {qc[QUO_W-2:0], 1'b1};
            end else begin
              qc = {qc[QUO_W-2:0], 1'b0};
            end
            if (rr >= dr) begin
              rr = rr - dr;
              qr = {qr[QUO_W-2:0], 1'b1};
            end else begin
              qr = {qr[QUO_W-2:0], 1'b0};
            end
          end
        end
        rem_col_nxt[s] = rc;
        rem_row_nxt[s] = rr;
        quo_col_nxt[s] = qc;
        quo_row_nxt[s] = qr;
      end

      // Valid bit
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= src_vld[s];
        end
      end

      // Payload
      always_ff @(posedge clk) begin
        if (rdy[s] && src_vld[s]) begin
          rem_col_r[s] <= rem_col_nxt[s];
          rem_row_r[s] <= rem_row_nxt[s];
          quo_col_r[s] <= quo_col_nxt[s];
          quo_row_r[s] <= quo_row_nxt[s];
          side_r[s]    <= src_side[s];
        end
      end

    end
  endgenerate

  // Response from the last stage
  assign rsp_valid    = vld_r[DIV_STAGES-1];
  assign rsp.quo_col  = quo_col_r[DIV_STAGES-1];
  assign rsp.quo_row  = quo_row_r[DIV_STAGES-1];
  assign rsp.side     = side_r[DIV_STAGES-1];

endmodule

### src/nsag_checker.sv
// ----------------------------------------------------------------------------
// nsag_checker: port-level checks of the scaler address generator
// Watches the result channel for handshake, reset and error-flag rules.
// ----------------------------------------------------------------------------
module nsag_checker
  import nsag_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Error results carry zero coordinates and offsets
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coord_error |->
      (out_data.in_col == '0) && (out_data.in_row == '0) &&
      (out_data.in_byte_offset == '0) && (out_data.out_byte_offset == '0))
    else $error("error result with nonzero fields");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind nearest_scaler_address_gen_top nsag_checker u_nsag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
